@@ design/rc_pulse_width_capture_core_macros.svh @@
// ----------------------------------------------------------------------------
// RC pulse width capture: assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RC_PULSE_WIDTH_CAPTURE_CORE_MACROS_SVH
`define RC_PULSE_WIDTH_CAPTURE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge outside reset.
`define RCPWC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rcpwc assertion failed");

// Condition that must never be seen outside reset.
`define RCPWC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rcpwc forbidden condition seen");

`else

`define RCPWC_ASSERT(lbl, clk, rst_n, prop)
`define RCPWC_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ design/rcpwc_pkg.sv @@
// ----------------------------------------------------------------------------
// RC pulse width capture: package
// Word types, register indexes and reset constants shared by all modules.
// ----------------------------------------------------------------------------
package rcpwc_pkg;

    // Fixed field widths
    localparam int FIELD_CH     = 8;   // channels carried in one word
    localparam int TS_BITS      = 24;  // timestamp field
    localparam int WIDTH_BITS   = 24;  // pulse width field
    localparam int WRAP_BITS    = 25;  // wrap period register
    localparam int THRESH_BITS  = 24;  // error threshold register
    localparam int CFG_IDX_BITS = 2;

    // Parameter defaults
    localparam int DEF_CHANNELS   = 8;
    localparam int DEF_STAMP_BITS = 24;

    // Register reset values
    localparam logic [WRAP_BITS-1:0]   WRAP_RESET   = WRAP_BITS'(2400000);
    localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(300000);

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_WRAP_PERIOD     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ERROR_THRESHOLD = 2'd1;

    typedef struct packed {
        logic [FIELD_CH-1:0] edge_mask;
        logic [TS_BITS-1:0]  timestamp;
    } in_word_t;

    typedef struct packed {
        logic [FIELD_CH-1:0]   updated_mask;
        logic [FIELD_CH-1:0]   rejected_mask;
        logic [WIDTH_BITS-1:0] width_ch0;
        logic [WIDTH_BITS-1:0] width_ch1;
        logic [WIDTH_BITS-1:0] width_ch2;
        logic [WIDTH_BITS-1:0] width_ch3;
        logic [WIDTH_BITS-1:0] width_ch4;
        logic [WIDTH_BITS-1:0] width_ch5;
        logic [WIDTH_BITS-1:0] width_ch6;
        logic [WIDTH_BITS-1:0] width_ch7;
    } out_word_t;

    // What one lane reports for the word being accepted
    typedef struct packed {
        logic                  updated;
        logic                  rejected;
        logic [WIDTH_BITS-1:0] width;
    } lane_status_t;

endpackage

@@ design/rc_pulse_width_capture_core.sv @@
// ----------------------------------------------------------------------------
// RC pulse width capture core
// Receiver pulse width capture over parallel channel lanes, one edge-event
// word per cycle while in_stall is low, with a two-word output buffer.
// ----------------------------------------------------------------------------
// One edge-event word is accepted per clock cycle while in_stall is low, and
// its result word is registered. Every channel has its own lane, so all edges
// of a word are handled together; the cycle time is set by each lane's
// start + wrap - now add and the threshold compare. The output side holds up
// to two result words (output register and skid), and in_stall rises only
// while both are full. Configuration writes are always ready and must be
// issued while no word is in flight.

module rc_pulse_width_capture_core
    import rcpwc_pkg::*;
#(
    parameter int CHANNELS   = DEF_CHANNELS,
    parameter int STAMP_BITS = DEF_STAMP_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Edge events
    input  logic                    in_valid,
    output logic                    in_stall,
    input  in_word_t                in_data,
    // Results
    output logic                    out_valid,
    input  logic                    out_stall,
    output out_word_t               out_data,
    // Register writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [WRAP_BITS-1:0]    cfg_data
);

    // Only channels that have an output field get a lane
    localparam int LANES = (CHANNELS < FIELD_CH) ? CHANNELS : FIELD_CH;

    logic [WRAP_BITS-1:0]   wrap_reg, wrap_next;
    logic [THRESH_BITS-1:0] thresh_reg, thresh_next;
    logic [STAMP_BITS-1:0]  now;
    logic                   busy;
    logic                   accept;
    lane_status_t           status [LANES];

    assign accept    = in_valid && !in_stall;
    assign in_stall  = busy;
    assign cfg_ready = 1'b1;

    // Timestamp taken to the stamp width
    if (STAMP_BITS >= TS_BITS)
    begin : g_ts_wide
        assign now = STAMP_BITS'(in_data.timestamp);
    end
    else
    begin : g_ts_narrow
        assign now = in_data.timestamp[STAMP_BITS-1:0];
    end

    // Configuration registers
    always_comb
    begin
        wrap_next   = wrap_reg;
        thresh_next = thresh_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WRAP_PERIOD:     wrap_next   = cfg_data;
                REG_ERROR_THRESHOLD: thresh_next = cfg_data[THRESH_BITS-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg   <= WRAP_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else
        begin
            wrap_reg   <= wrap_next;
            thresh_reg <= thresh_next;
        end
    end

    // Channel lanes
    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        rcpwc_lane #(
            .STAMP_BITS (STAMP_BITS)
        ) u_lane (
            .clk             (clk),
            .rst_n           (rst_n),
            .accept          (accept),
            .edge_hit        (in_data.edge_mask[j]),
            .now             (now),
            .wrap_period     (wrap_reg),
            .error_threshold (thresh_reg),
            .status          (status[j])
        );
    end

    // Merge and output buffer
    rcpwc_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .status    (status),
        .busy      (busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ design/rcpwc_lane.sv @@
// ----------------------------------------------------------------------------
// RC pulse width capture: channel lane
// Holds one channel's arm flag, start stamp and last width; measures the
// elapsed count on an edge and decides accept or reject.
// ----------------------------------------------------------------------------
`include "rc_pulse_width_capture_core_macros.svh"

module rcpwc_lane
    import rcpwc_pkg::*;
#(
    parameter int STAMP_BITS = DEF_STAMP_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   edge_hit,
    input  logic [STAMP_BITS-1:0]  now,
    input  logic [WRAP_BITS-1:0]   wrap_period,
    input  logic [THRESH_BITS-1:0] error_threshold,
    output lane_status_t           status
);

    // count holds start + wrap - now without loss
    localparam int CNT_W = ((STAMP_BITS > WRAP_BITS) ? STAMP_BITS : WRAP_BITS) + 1;

    logic                  armed_reg, armed_next;
    logic [STAMP_BITS-1:0] start_reg, start_next;
    logic [WIDTH_BITS-1:0] width_reg, width_next;

    logic [CNT_W-1:0] count;
    logic             over;

    // Elapsed count on a down-counter; equal stamps count as a wrap
    always_comb
    begin
        if (start_reg > now)
            count = CNT_W'(start_reg) - CNT_W'(now);
        else
            count = CNT_W'(start_reg) + CNT_W'(wrap_period) - CNT_W'(now);
        over = count > CNT_W'(error_threshold);
    end

    // Result flags for this word
    always_comb
    begin
        status.updated  = edge_hit && armed_reg && !over;
        status.rejected = edge_hit && armed_reg && over;
        status.width    = status.updated ? count[WIDTH_BITS-1:0] : width_reg;
    end

    // State update
    always_comb
    begin
        armed_next = armed_reg;
        start_next = start_reg;
        width_next = width_reg;
        if (accept && edge_hit)
        begin
            if (!armed_reg || over)
            begin
                armed_next = 1'b1;
                start_next = now;
            end
            else
            begin
                armed_next = 1'b0;
                width_next = count[WIDTH_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            start_reg <= '0;
            width_reg <= '0;
        end
        else
        begin
            armed_reg <= armed_next;
            start_reg <= start_next;
            width_reg <= width_next;
        end
    end

    // An idle channel arms on its first edge
    `RCPWC_ASSERT(a_lane_arm, clk, rst_n,
        (accept && edge_hit && !armed_reg) |=> (armed_reg && start_reg == $past(now)))
    // A stored width disarms the channel and shows up as the held width
    `RCPWC_ASSERT(a_lane_store, clk, rst_n,
        (accept && status.updated) |=> (!armed_reg && width_reg == $past(status.width)))
    // A rejected count restarts from the current stamp and keeps the old width
    `RCPWC_ASSERT(a_lane_reject, clk, rst_n,
        (accept && status.rejected) |=>
            (armed_reg && start_reg == $past(now) && $stable(width_reg)))

endmodule

@@ design/rcpwc_merge.sv @@
// ----------------------------------------------------------------------------
// RC pulse width capture: merge and output buffer
// Packs the lane results into one result word and holds it in an output
// register backed by a skid register.
// ----------------------------------------------------------------------------
`include "rc_pulse_width_capture_core_macros.svh"

module rcpwc_merge
    import rcpwc_pkg::*;
#(
    parameter int LANES = FIELD_CH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  lane_status_t status [LANES],
    output logic         busy,
    output logic         out_valid,
    input  logic         out_stall,
    output out_word_t    out_data
);

    logic [FIELD_CH-1:0]   upd_mask;
    logic [FIELD_CH-1:0]   rej_mask;
    logic [WIDTH_BITS-1:0] widths [FIELD_CH];
    out_word_t             new_word;

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_word_t out_word_reg, out_word_next;
    out_word_t skid_word_reg, skid_word_next;
    logic      out_fire;

    // Gather lane results; fields with no lane read zero
    for (genvar j = 0; j < FIELD_CH; j++)
    begin : g_gather
        if (j < LANES)
        begin : g_live
            assign upd_mask[j] = status[j].updated;
            assign rej_mask[j] = status[j].rejected;
            assign widths[j]   = status[j].width;
        end
        else
        begin : g_none
            assign upd_mask[j] = 1'b0;
            assign rej_mask[j] = 1'b0;
            assign widths[j]   = '0;
        end
    end

    always_comb
    begin
        new_word.updated_mask  = upd_mask;
        new_word.rejected_mask = rej_mask;
        new_word.width_ch0     = widths[0];
        new_word.width_ch1     = widths[1];
        new_word.width_ch2     = widths[2];
        new_word.width_ch3     = widths[3];
        new_word.width_ch4     = widths[4];
        new_word.width_ch5     = widths[5];
        new_word.width_ch6     = widths[6];
        new_word.width_ch7     = widths[7];
    end

    assign out_fire  = out_valid_reg && !out_stall;
    assign busy      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // Output register plus skid; new words are taken only with the skid empty
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_word_next   = skid_word_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (accept)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_word_next  = new_word;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_word_next  = new_word;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    // The skid only holds a word behind a held output word
    `RCPWC_ASSERT_NEVER(a_merge_skid_alone, clk, rst_n, skid_valid_reg && !out_valid_reg)
    // A word taken behind a stalled output lands in the skid
    `RCPWC_ASSERT(a_merge_to_skid, clk, rst_n,
        (accept && out_valid_reg && out_stall) |=> skid_valid_reg)
    // A drained skid moves forward into the output register
    `RCPWC_ASSERT(a_merge_drain, clk, rst_n,
        (out_fire && skid_valid_reg) |=>
            (out_valid_reg && !skid_valid_reg && out_word_reg == $past(skid_word_reg)))

endmodule
